@@ hw/rtl/lgd_pkg.sv @@
// ---------------------------------------------------------------------------
// lgd_pkg: shared types and constants for the lattice gas step block
// Mode and rotation codes, sequencer states, register map and defaults.
// ---------------------------------------------------------------------------
package lgd_pkg;

  // grid size defaults
  localparam int GRID_X_DEF = 256;
  localparam int GRID_Y_DEF = 256;

  // request queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // field widths
  localparam int MODE_W   = 2;
  localparam int COORD_W  = 8;
  localparam int DIR_W    = 2;
  localparam int RAND_W   = 16;
  localparam int OCC_W    = 4;
  localparam int DENS_W   = 3;
  localparam int STAY_W   = 17;
  localparam int TURN_W   = 16;
  localparam int NUM_DIRS = 4;

  // register map (index is paddr[2])
  localparam logic REG_STAY_LIMIT = 1'b0;
  localparam logic REG_TURN_WIDTH = 1'b1;

  localparam logic [STAY_W-1:0] STAY_LIMIT_RST = 17'd16384;
  localparam logic [TURN_W-1:0] TURN_WIDTH_RST = 16'd16384;

  typedef enum logic [1:0] {
    MODE_PLACE = 2'd0,
    MODE_STEP  = 2'd1,
    MODE_SWAP  = 2'd2,
    MODE_READ  = 2'd3
  } mode_t;

  // left rotation amount of the four direction bits
  typedef enum logic [1:0] {
    ROT_KEEP  = 2'd0,
    ROT_LEFT  = 2'd1,
    ROT_TWO   = 2'd2,
    ROT_RIGHT = 2'd3
  } rot_t;

  typedef enum logic [1:0] {
    ST_CLEAR = 2'd0,
    ST_IDLE  = 2'd1,
    ST_EXEC  = 2'd2
  } lgd_state_t;

endpackage

@@ hw/rtl/lgd_ram.sv @@
// ---------------------------------------------------------------------------
// lgd_ram: generic single-write, single-read RAM
// One write port, one read port, read data registered and held between reads.
// ---------------------------------------------------------------------------
module lgd_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ hw/rtl/lgd_queue.sv @@
// ---------------------------------------------------------------------------
// lgd_queue: short request queue
// Small FIFO decoupling the front classifier from the back executor.
// ---------------------------------------------------------------------------
module lgd_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = lgd_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             full,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;

  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full && !pop))
    else $error("push into full request queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && empty))
    else $error("pop from empty request queue");
`endif

endmodule

@@ hw/rtl/lgd_front.sv @@
// ---------------------------------------------------------------------------
// lgd_front: request classifier
// Wraps coordinates, finds the four neighbors and picks the rotation band.
// ---------------------------------------------------------------------------
module lgd_front #(
  parameter int GRID_X = lgd_pkg::GRID_X_DEF,
  parameter int GRID_Y = lgd_pkg::GRID_Y_DEF,
  parameter int XW     = $clog2(GRID_X),
  parameter int YW     = $clog2(GRID_Y),
  parameter int CMD_W  = 3 * lgd_pkg::DIR_W + 3 * XW + 3 * YW
) (
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [lgd_pkg::MODE_W-1:0]  in_mode,
  input  logic [lgd_pkg::COORD_W-1:0] in_x_coord,
  input  logic [lgd_pkg::COORD_W-1:0] in_y_coord,
  input  logic [lgd_pkg::DIR_W-1:0]   in_direction,
  input  logic [lgd_pkg::RAND_W-1:0]  in_random_value,
  input  logic [lgd_pkg::STAY_W-1:0]  stay_limit,
  input  logic [lgd_pkg::TURN_W-1:0]  turn_width,
  input  logic                        clearing,
  input  logic                        q_full,
  output logic                        q_push,
  output logic [CMD_W-1:0]            q_data
);

  typedef struct packed {
    lgd_pkg::mode_t              mode;
    lgd_pkg::rot_t               rot;
    logic [lgd_pkg::DIR_W-1:0]   dir;
    logic [XW-1:0]               x;
    logic [XW-1:0]               xp;
    logic [XW-1:0]               xm;
    logic [YW-1:0]               y;
    logic [YW-1:0]               yp;
    logic [YW-1:0]               ym;
  } cmd_t;

  localparam int NCOORD = 2 ** lgd_pkg::COORD_W;

  logic [XW-1:0] xmod_tab [NCOORD];
  logic [YW-1:0] ymod_tab [NCOORD];
  logic [XW-1:0] x_w;
  logic [YW-1:0] y_w;
  logic [lgd_pkg::STAY_W:0]   band1;
  logic [lgd_pkg::STAY_W+1:0] band2;
  logic [lgd_pkg::STAY_W+1:0] r_ext;
  cmd_t cmd;

  // constant wrap tables, one entry per raw coordinate
  for (genvar g = 0; g < NCOORD; g++) begin : g_mod
    assign xmod_tab[g] = XW'(g % GRID_X);
    assign ymod_tab[g] = YW'(g % GRID_Y);
  end

  assign x_w = xmod_tab[in_x_coord];
  assign y_w = ymod_tab[in_y_coord];

  assign band1 = {1'b0, stay_limit} + {2'b00, turn_width};
  assign band2 = {2'b00, stay_limit} + {2'b00, turn_width, 1'b0};
  assign r_ext = {3'b000, in_random_value};

  always_comb begin
    cmd.mode = lgd_pkg::mode_t'(in_mode);
    cmd.dir  = in_direction;
    cmd.x    = x_w;
    cmd.y    = y_w;
    cmd.xp   = (x_w == XW'(GRID_X - 1)) ? '0 : x_w + XW'(1);
    cmd.xm   = (x_w == '0) ? XW'(GRID_X - 1) : x_w - XW'(1);
    cmd.yp   = (y_w == YW'(GRID_Y - 1)) ? '0 : y_w + YW'(1);
    cmd.ym   = (y_w == '0) ? YW'(GRID_Y - 1) : y_w - YW'(1);
    priority if (r_ext <= {2'b00, stay_limit}) begin
      cmd.rot = lgd_pkg::ROT_KEEP;
    end else if (r_ext <= {1'b0, band1}) begin
      cmd.rot = lgd_pkg::ROT_LEFT;
    end else if (r_ext <= band2) begin
      cmd.rot = lgd_pkg::ROT_RIGHT;
    end else begin
      cmd.rot = lgd_pkg::ROT_TWO;
    end
  end

  assign in_stall = clearing || q_full;
  assign q_push   = in_valid && !in_stall;
  assign q_data   = CMD_W'(cmd);

endmodule

@@ hw/rtl/lgd_back.sv @@
// ---------------------------------------------------------------------------
// lgd_back: cell store and request executor
// Four per-direction bit planes, read then write per request, result register.
// ---------------------------------------------------------------------------
module lgd_back #(
  parameter int GRID_X = lgd_pkg::GRID_X_DEF,
  parameter int GRID_Y = lgd_pkg::GRID_Y_DEF,
  parameter int XW     = $clog2(GRID_X),
  parameter int YW     = $clog2(GRID_Y),
  parameter int CMD_W  = 3 * lgd_pkg::DIR_W + 3 * XW + 3 * YW
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_empty,
  input  logic [CMD_W-1:0]           q_data,
  output logic                       q_pop,
  output logic                       clearing,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [lgd_pkg::OCC_W-1:0]  out_occupancy,
  output logic [lgd_pkg::DENS_W-1:0] out_density
);

  typedef struct packed {
    lgd_pkg::mode_t              mode;
    lgd_pkg::rot_t               rot;
    logic [lgd_pkg::DIR_W-1:0]   dir;
    logic [XW-1:0]               x;
    logic [XW-1:0]               xp;
    logic [XW-1:0]               xm;
    logic [YW-1:0]               y;
    logic [YW-1:0]               yp;
    logic [YW-1:0]               ym;
  } cmd_t;

  localparam int AW    = 1 + XW + YW;
  localparam int DEPTH = 2 ** AW;
  localparam int ND    = lgd_pkg::NUM_DIRS;

  function automatic logic [lgd_pkg::OCC_W-1:0] rotate4(
    input logic [lgd_pkg::OCC_W-1:0] v,
    input lgd_pkg::rot_t             k
  );
    logic [lgd_pkg::OCC_W-1:0] res;
    unique case (k)
      lgd_pkg::ROT_KEEP:  res = v;
      lgd_pkg::ROT_LEFT:  res = {v[2:0], v[3]};
      lgd_pkg::ROT_TWO:   res = {v[1:0], v[3:2]};
      lgd_pkg::ROT_RIGHT: res = {v[0], v[3:1]};
      default:            res = v;
    endcase
    return res;
  endfunction

  function automatic logic [lgd_pkg::DENS_W-1:0] DENS_W_CAST(
    input logic [lgd_pkg::OCC_W-1:0] v
  );
    return {2'b00, v[0]} + {2'b00, v[1]} + {2'b00, v[2]} + {2'b00, v[3]};
  endfunction

  lgd_pkg::lgd_state_t state_r, state_nxt;
  logic [AW-1:0]       clr_addr_r, clr_addr_nxt;
  logic                cur_r, cur_nxt;
  cmd_t                cmd_r;
  logic                out_valid_r, out_valid_nxt;
  logic [lgd_pkg::OCC_W-1:0]  out_occ_r, out_occ_nxt;
  logic [lgd_pkg::DENS_W-1:0] out_dens_r, out_dens_nxt;

  logic                        fire;
  logic                        rd_en;
  logic [AW-1:0]               rd_addr;
  logic [ND-1:0]               rd_bits;
  logic [ND-1:0]               wr_en;
  logic [ND-1:0]               wr_bit;
  logic [AW-1:0]               wr_addr [ND];
  logic [lgd_pkg::OCC_W-1:0]   occ;
  logic [lgd_pkg::OCC_W-1:0]   rot_bits;
  cmd_t                        q_cmd;

  assign q_cmd    = cmd_t'(q_data);
  assign occ      = rd_bits;
  assign rot_bits = rotate4(occ, cmd_r.rot);
  assign fire     = (state_r == lgd_pkg::ST_EXEC) && (!out_valid_r || !out_stall);
  assign clearing = (state_r == lgd_pkg::ST_CLEAR);

  for (genvar d = 0; d < ND; d++) begin : g_plane
    lgd_ram #(
      .WIDTH(1),
      .DEPTH(DEPTH)
    ) u_plane (
      .clk  (clk),
      .we   (wr_en[d]),
      .waddr(wr_addr[d]),
      .wdata(wr_bit[d]),
      .re   (rd_en),
      .raddr(rd_addr),
      .rdata(rd_bits[d])
    );
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lgd_pkg::ST_CLEAR: begin
        if (clr_addr_r == AW'(DEPTH - 1)) begin
          state_nxt = lgd_pkg::ST_IDLE;
        end
      end
      lgd_pkg::ST_IDLE: begin
        if (!q_empty) begin
          state_nxt = lgd_pkg::ST_EXEC;
        end
      end
      lgd_pkg::ST_EXEC: begin
        if (fire) begin
          state_nxt = lgd_pkg::ST_IDLE;
        end
      end
      default: state_nxt = lgd_pkg::ST_CLEAR;
    endcase
  end

  // outputs and datapath controls
  always_comb begin
    q_pop         = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = {cur_r, q_cmd.x, q_cmd.y};
    clr_addr_nxt  = clr_addr_r;
    cur_nxt       = cur_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_occ_nxt   = out_occ_r;
    out_dens_nxt  = out_dens_r;
    wr_en         = '0;
    wr_bit        = '0;
    for (int d = 0; d < ND; d++) begin
      wr_addr[d] = clr_addr_r;
    end
    unique case (state_r)
      lgd_pkg::ST_CLEAR: begin
        wr_en        = '1;
        clr_addr_nxt = clr_addr_r + AW'(1);
      end
      lgd_pkg::ST_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          rd_en = 1'b1;
        end
      end
      lgd_pkg::ST_EXEC: begin
        if (fire) begin
          out_valid_nxt = 1'b1;
          out_occ_nxt   = occ;
          out_dens_nxt  = DENS_W_CAST(occ);
          unique case (cmd_r.mode)
            lgd_pkg::MODE_PLACE: begin
              for (int d = 0; d < ND; d++) begin
                wr_en[d]   = (cmd_r.dir == lgd_pkg::DIR_W'(d));
                wr_bit[d]  = 1'b1;
                wr_addr[d] = {cur_r, cmd_r.x, cmd_r.y};
              end
            end
            lgd_pkg::MODE_STEP: begin
              wr_en      = '1;
              wr_bit     = rot_bits;
              wr_addr[0] = {~cur_r, cmd_r.xp, cmd_r.y};
              wr_addr[1] = {~cur_r, cmd_r.x, cmd_r.yp};
              wr_addr[2] = {~cur_r, cmd_r.xm, cmd_r.y};
              wr_addr[3] = {~cur_r, cmd_r.x, cmd_r.ym};
            end
            lgd_pkg::MODE_SWAP: begin
              cur_nxt      = ~cur_r;
              out_occ_nxt  = '0;
              out_dens_nxt = '0;
            end
            lgd_pkg::MODE_READ: begin
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lgd_pkg::ST_CLEAR;
      clr_addr_r  <= '0;
      cur_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      cur_r       <= cur_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd_r <= q_cmd;
    end
    out_occ_r  <= out_occ_nxt;
    out_dens_r <= out_dens_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_occupancy = out_occ_r;
  assign out_density   = out_dens_r;

`ifndef SYNTHESIS
  a_clear_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lgd_pkg::ST_CLEAR) |-> !out_valid_r)
    else $error("result presented during clearing pass");

  a_swap_toggles: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && cmd_r.mode == lgd_pkg::MODE_SWAP) |=> (cur_r != $past(cur_r)))
    else $error("swap request did not exchange buffers");

  a_pop_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (state_r == lgd_pkg::ST_EXEC) && !clearing)
    else $error("popped request not executed");
`endif

endmodule

@@ hw/rtl/lattice_gas_diffusion_step.sv @@
// ---------------------------------------------------------------------------
// lattice_gas_diffusion_step: four-direction lattice gas on a wrapping grid
// Double-buffered occupancy store with place, step, swap and read requests.
// ---------------------------------------------------------------------------
// Usage:
//  - Requests enter on the in_ channel (valid/stall): mode, cell coordinates,
//    direction for place, random fraction for step. Every request returns
//    exactly one result on the out_ channel: the cell's four direction bits
//    in the current buffer before the action, and their count (both zero on swap).
//  - Two config registers on the APB port: stay_limit at 0x0, turn_width at
//    0x4. Write them only while no request is in flight.
//  - Each request is queued, popped into the back end as its cell is read,
//    then its result is registered. The back end finishes one request before
//    taking the next: it reads, then writes, the four per-direction bit planes.
//  - The front end classifies requests into a 2-entry queue. While a result
//    waits on out_stall, up to three more requests are taken (one held in the
//    back end, two queued); after that in_stall rises. A stalled result holds
//    in its output register.
//  - After reset the back end clears both buffers, one cell per cycle, all
//    2 * 2^clog2(GRID_X) * 2^clog2(GRID_Y) cells (131072 for 256x256).
//    in_stall stays high during that pass; config writes are taken as usual.
// ---------------------------------------------------------------------------
module lattice_gas_diffusion_step #(
  parameter int GRID_X = lgd_pkg::GRID_X_DEF,
  parameter int GRID_Y = lgd_pkg::GRID_Y_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // request channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [lgd_pkg::MODE_W-1:0]  in_mode,
  input  logic [lgd_pkg::COORD_W-1:0] in_x_coord,
  input  logic [lgd_pkg::COORD_W-1:0] in_y_coord,
  input  logic [lgd_pkg::DIR_W-1:0]   in_direction,
  input  logic [lgd_pkg::RAND_W-1:0]  in_random_value,
  // result channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [lgd_pkg::OCC_W-1:0]   out_occupancy,
  output logic [lgd_pkg::DENS_W-1:0]  out_density,
  // config port
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [2:0]                  cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready
);

  localparam int XW    = $clog2(GRID_X);
  localparam int YW    = $clog2(GRID_Y);
  localparam int CMD_W = 3 * lgd_pkg::DIR_W + 3 * XW + 3 * YW;

  logic [lgd_pkg::STAY_W-1:0] stay_limit_r, stay_limit_nxt;
  logic [lgd_pkg::TURN_W-1:0] turn_width_r, turn_width_nxt;
  logic                       cfg_wr;
  logic                       reg_sel;

  logic             q_push;
  logic             q_pop;
  logic [CMD_W-1:0] q_wdata;
  logic [CMD_W-1:0] q_rdata;
  logic             q_full;
  logic             q_empty;
  logic             clearing;

  // register write on the APB access phase, index from paddr[2]
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign reg_sel    = cfg_paddr[2];

  always_comb begin
    stay_limit_nxt = stay_limit_r;
    turn_width_nxt = turn_width_r;
    if (cfg_wr) begin
      unique case (reg_sel)
        lgd_pkg::REG_STAY_LIMIT: stay_limit_nxt = cfg_pwdata[lgd_pkg::STAY_W-1:0];
        lgd_pkg::REG_TURN_WIDTH: turn_width_nxt = cfg_pwdata[lgd_pkg::TURN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      lgd_pkg::REG_STAY_LIMIT: cfg_prdata = 32'(stay_limit_r);
      lgd_pkg::REG_TURN_WIDTH: cfg_prdata = 32'(turn_width_r);
      default:                 cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stay_limit_r <= lgd_pkg::STAY_LIMIT_RST;
      turn_width_r <= lgd_pkg::TURN_WIDTH_RST;
    end else begin
      stay_limit_r <= stay_limit_nxt;
      turn_width_r <= turn_width_nxt;
    end
  end

  // front: wrap coordinates, neighbors, rotation band
  lgd_front #(
    .GRID_X(GRID_X),
    .GRID_Y(GRID_Y),
    .XW    (XW),
    .YW    (YW),
    .CMD_W (CMD_W)
  ) u_front (
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_mode        (in_mode),
    .in_x_coord     (in_x_coord),
    .in_y_coord     (in_y_coord),
    .in_direction   (in_direction),
    .in_random_value(in_random_value),
    .stay_limit     (stay_limit_r),
    .turn_width     (turn_width_r),
    .clearing       (clearing),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_data         (q_wdata)
  );

  // short queue so front and back stall independently
  lgd_queue #(
    .WIDTH(CMD_W),
    .DEPTH(lgd_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_data(q_wdata),
    .pop      (q_pop),
    .pop_data (q_rdata),
    .full     (q_full),
    .empty    (q_empty)
  );

  // back: bit planes, read/modify/write sequencing, result register
  lgd_back #(
    .GRID_X(GRID_X),
    .GRID_Y(GRID_Y),
    .XW    (XW),
    .YW    (YW),
    .CMD_W (CMD_W)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_empty      (q_empty),
    .q_data       (q_rdata),
    .q_pop        (q_pop),
    .clearing     (clearing),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_occupancy(out_occupancy),
    .out_density  (out_density)
  );

endmodule
